// ===== src/ngss_pkg.sv =====
// Package for the nearest grid snap search core.
// Holds the shared sizes, command and kind codes, controller states and the
// command and status structs between the controller and the datapath.
`default_nettype none

package ngss_pkg;

   localparam int MAX_POINTS_DEF = 256;
   localparam int MAX_AXIS_SEGS_DEF = 64;
   localparam int MAX_LEVEL_SEGS_DEF = 64;

   localparam int COORD_W = 32;
   localparam int TOL_W = 31;
   localparam int DSQ_W = 64;
   localparam int IDX_OUT_W = 8;
   localparam int CSR_IDX_W = 2;

   localparam int DIFF_W = COORD_W + 1;
   localparam int MUL_W = COORD_W + 2;
   localparam int PROD_W = 2 * MUL_W;
   localparam int SQ_W = 2 * COORD_W + 2;
   localparam int DOT_W = PROD_W;
   localparam int T_W = 17;
   localparam int REM_W = SQ_W + 1;
   localparam int TSQ_W = 2 * TOL_W;
   localparam int DIV_STEPS = 16;

   localparam logic [SQ_W-1:0] DEGEN_LEN_SQ = SQ_W'(4295);
   localparam logic [T_W-1:0] T_ONE = T_W'(65536);

   typedef enum logic [2:0] {
      CMD_CLEAR      = 3'd0,
      CMD_LOAD_POINT = 3'd1,
      CMD_LOAD_AXIS  = 3'd2,
      CMD_LOAD_LEVEL = 3'd3,
      CMD_QUERY      = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_ORIGIN = 3'd1,
      KIND_POINT  = 3'd2,
      KIND_AXIS   = 3'd3,
      KIND_LEVEL  = 3'd4
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X = 2'd0,
      CSR_ORIGIN_Y = 2'd1,
      CSR_ORIGIN_Z = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      MUL_NONE, MUL_TOL, MUL_DIFF, MUL_VV, MUL_VW, MUL_VT
   } mul_op_type;

   typedef enum logic [1:0] {
      ACC_NONE, ACC_DIST, ACC_LEN, ACC_DOT
   } acc_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_ORG, ST_DIST, ST_CMP, ST_NEXT, ST_PT_RD, ST_PT_LD,
      ST_SEG_RD, ST_SEG_LD, ST_MAC, ST_CHK, ST_DIV, ST_PROJ, ST_FINISH
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       exec;
      logic       best_clr;
      mul_op_type mul_op;
      logic [1:0] axis;
      acc_op_type acc_op;
      logic       tol_wr;
      logic       cand_org;
      logic       cand_pt;
      logic       dist_clr;
      logic       seg_ld;
      logic       t_zero;
      logic       t_one;
      logic       div_init;
      logic       div_step;
      logic       cand_proj;
      logic [1:0] wr_axis;
      logic       cmp_upd;
      kind_type   kind;
      logic       idx_clr;
      logic       idx_inc;
      logic       rd_en;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       pt_nz;
      logic       ax_nz;
      logic       lv_nz;
      logic       pt_last;
      logic       ax_last;
      logic       lv_last;
      logic       degen;
      logic       dot_pos;
      logic       dot_ge_len;
      logic       best_have;
      logic       best_point;
   } dp_sts_type;

endpackage

`default_nettype wire

// ===== src/ngss_ctrl.sv =====
// Controller state machine of the nearest grid snap search core.
// Sequences loads, the origin and point scan and the segment projections.
// Depends on ngss_pkg.
`default_nettype none

module ngss_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   input  ngss_pkg::dp_sts_type    sts,
   output ngss_pkg::dp_cmd_type    cmd
);
   import ngss_pkg::*;

   state_type  state_ff, state_in;
   kind_type   kind_ff, kind_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff <= KIND_NONE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff <= kind_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      req_stall = 1'b1;
      cmd = '0;
      cmd.mul_op = MUL_NONE;
      cmd.acc_op = ACC_NONE;
      cmd.kind = kind_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.cmd == CMD_QUERY) begin
               cmd.best_clr = 1'b1;
               cmd.mul_op = MUL_TOL;
               state_in = ST_ORG;
            end else begin
               cmd.exec = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_ORG: begin
            cmd.tol_wr = 1'b1;
            cmd.cand_org = 1'b1;
            cmd.dist_clr = 1'b1;
            cmd.idx_clr = 1'b1;
            kind_in = KIND_ORIGIN;
            cnt_in = '0;
            state_in = ST_DIST;
         end
         ST_DIST: begin
            if (cnt_ff < 4'd3) begin
               cmd.mul_op = MUL_DIFF;
               cmd.axis = cnt_ff[1:0];
            end
            if (cnt_ff != 4'd0) begin
               cmd.acc_op = ACC_DIST;
            end
            if (cnt_ff == 4'd3) begin
               cnt_in = '0;
               state_in = ST_CMP;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_CMP: begin
            cmd.cmp_upd = 1'b1;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            state_in = ST_FINISH;
            case (kind_ff)
               KIND_ORIGIN, KIND_POINT: begin
                  if (kind_ff == KIND_ORIGIN && sts.pt_nz) begin
                     cmd.idx_clr = 1'b1;
                     kind_in = KIND_POINT;
                     state_in = ST_PT_RD;
                  end else if (kind_ff == KIND_POINT && !sts.pt_last) begin
                     cmd.idx_inc = 1'b1;
                     state_in = ST_PT_RD;
                  end else if (sts.best_have && sts.best_point) begin
                     state_in = ST_FINISH;
                  end else if (sts.ax_nz) begin
                     cmd.idx_clr = 1'b1;
                     kind_in = KIND_AXIS;
                     state_in = ST_SEG_RD;
                  end else if (sts.lv_nz) begin
                     cmd.idx_clr = 1'b1;
                     kind_in = KIND_LEVEL;
                     state_in = ST_SEG_RD;
                  end
               end
               KIND_AXIS: begin
                  if (!sts.ax_last) begin
                     cmd.idx_inc = 1'b1;
                     state_in = ST_SEG_RD;
                  end else if (sts.lv_nz) begin
                     cmd.idx_clr = 1'b1;
                     kind_in = KIND_LEVEL;
                     state_in = ST_SEG_RD;
                  end
               end
               KIND_LEVEL: begin
                  if (!sts.lv_last) begin
                     cmd.idx_inc = 1'b1;
                     state_in = ST_SEG_RD;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_PT_RD: begin
            cmd.rd_en = 1'b1;
            state_in = ST_PT_LD;
         end
         ST_PT_LD: begin
            cmd.cand_pt = 1'b1;
            cmd.dist_clr = 1'b1;
            cnt_in = '0;
            state_in = ST_DIST;
         end
         ST_SEG_RD: begin
            cmd.rd_en = 1'b1;
            state_in = ST_SEG_LD;
         end
         ST_SEG_LD: begin
            cmd.seg_ld = 1'b1;
            cnt_in = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            if (cnt_ff < 4'd6) begin
               cmd.mul_op = cnt_ff[0] ? MUL_VW : MUL_VV;
               cmd.axis = cnt_ff[2:1];
            end
            if (cnt_ff != 4'd0) begin
               cmd.acc_op = cnt_ff[0] ? ACC_LEN : ACC_DOT;
            end
            if (cnt_ff == 4'd6) begin
               cnt_in = '0;
               state_in = ST_CHK;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_CHK: begin
            cnt_in = '0;
            if (sts.degen) begin
               state_in = ST_NEXT;
            end else if (!sts.dot_pos) begin
               cmd.t_zero = 1'b1;
               state_in = ST_PROJ;
            end else if (sts.dot_ge_len) begin
               cmd.t_one = 1'b1;
               state_in = ST_PROJ;
            end else begin
               cmd.div_init = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == 4'(DIV_STEPS - 1)) begin
               cnt_in = '0;
               state_in = ST_PROJ;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_PROJ: begin
            if (cnt_ff < 4'd3) begin
               cmd.mul_op = MUL_VT;
               cmd.axis = cnt_ff[1:0];
            end
            if (cnt_ff != 4'd0) begin
               cmd.cand_proj = 1'b1;
               cmd.wr_axis = 2'(cnt_ff - 4'd1);
            end
            if (cnt_ff == 4'd3) begin
               cmd.dist_clr = 1'b1;
               cnt_in = '0;
               state_in = ST_DIST;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/ngss_dpath.sv =====
// Datapath of the nearest grid snap search core: tables, counts, the shared
// multiplier, accumulators, divider, best-candidate and result registers.
// Depends on ngss_pkg.
`default_nettype none

module ngss_dpath #(
   parameter int MAX_POINTS = ngss_pkg::MAX_POINTS_DEF,
   parameter int MAX_AXIS_SEGS = ngss_pkg::MAX_AXIS_SEGS_DEF,
   parameter int MAX_LEVEL_SEGS = ngss_pkg::MAX_LEVEL_SEGS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire  [2:0]                           req_command,
   input  wire  [ngss_pkg::COORD_W-1:0]         req_ax,
   input  wire  [ngss_pkg::COORD_W-1:0]         req_ay,
   input  wire  [ngss_pkg::COORD_W-1:0]         req_az,
   input  wire  [ngss_pkg::COORD_W-1:0]         req_bx,
   input  wire  [ngss_pkg::COORD_W-1:0]         req_by,
   input  wire  [ngss_pkg::COORD_W-1:0]         req_bz,
   input  wire  [ngss_pkg::TOL_W-1:0]           req_tolerance,
   input  wire                                  csr_we,
   input  wire  [ngss_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [ngss_pkg::COORD_W-1:0]         csr_wdata,
   input  ngss_pkg::dp_cmd_type                 cmd,
   output ngss_pkg::dp_sts_type                 sts,
   output logic                                 rsp_snapped,
   output logic [2:0]                           rsp_snap_kind,
   output logic [ngss_pkg::COORD_W-1:0]         rsp_snap_x,
   output logic [ngss_pkg::COORD_W-1:0]         rsp_snap_y,
   output logic [ngss_pkg::COORD_W-1:0]         rsp_snap_z,
   output logic [ngss_pkg::DSQ_W-1:0]           rsp_dist_sq,
   output logic [ngss_pkg::IDX_OUT_W-1:0]       rsp_entry_index,
   output logic                                 rsp_table_full
);
   import ngss_pkg::*;

   localparam int PAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int AAW = (MAX_AXIS_SEGS > 1) ? $clog2(MAX_AXIS_SEGS) : 1;
   localparam int LAW = (MAX_LEVEL_SEGS > 1) ? $clog2(MAX_LEVEL_SEGS) : 1;
   localparam int PCW = $clog2(MAX_POINTS + 1);
   localparam int ACW = $clog2(MAX_AXIS_SEGS + 1);
   localparam int LCW = $clog2(MAX_LEVEL_SEGS + 1);
   localparam int MAX_SEG = (MAX_AXIS_SEGS > MAX_LEVEL_SEGS) ? MAX_AXIS_SEGS
                                                            : MAX_LEVEL_SEGS;
   localparam int MAX_ALL = (MAX_POINTS > MAX_SEG) ? MAX_POINTS : MAX_SEG;
   localparam int IW = $clog2(MAX_ALL + 1);
   localparam int PT_W = 3 * COORD_W;
   localparam int SEG_W = 6 * COORD_W;

   logic [PT_W-1:0]  pt_mem [MAX_POINTS];
   logic [SEG_W-1:0] ax_mem [MAX_AXIS_SEGS];
   logic [SEG_W-1:0] lv_mem [MAX_LEVEL_SEGS];
   logic [PT_W-1:0]  pt_rd_ff;
   logic [SEG_W-1:0] ax_rd_ff, lv_rd_ff, seg_rd;

   logic [PCW-1:0] pt_cnt_ff;
   logic [ACW-1:0] ax_cnt_ff;
   logic [LCW-1:0] lv_cnt_ff;
   logic           pt_full, ax_full, lv_full, pt_we, ax_we, lv_we;
   logic [IW-1:0]  idx_ff;
   logic [IW:0]    idx_nx;

   logic [2:0]              cmd_ff;
   logic [COORD_W-1:0]      a_ff [3];
   logic [COORD_W-1:0]      b_ff [3];
   logic [TOL_W-1:0]        tol_ff;
   logic [COORD_W-1:0]      org_ff [3];

   logic [TSQ_W-1:0]        tol_sq_ff;
   logic [COORD_W-1:0]      cand_ff [3];
   logic [COORD_W-1:0]      s_ff [3];
   logic signed [DIFF_W-1:0] v_ff [3];
   logic signed [DIFF_W-1:0] w_ff [3];
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic [SQ_W-1:0]         dist_ff, len_ff;
   logic signed [DOT_W-1:0] dot_ff;
   logic [REM_W-1:0]        rem_ff, rem_sh;
   logic [T_W-1:0]          t_ff;

   logic [COORD_W-1:0]      q_sel, c_sel;
   logic signed [DIFF_W-1:0] diff, v_sel, w_sel;
   logic                    upd;

   logic                    best_have_ff;
   kind_type                best_kind_ff;
   logic [COORD_W-1:0]      best_p_ff [3];
   logic [SQ_W-1:0]         best_dsq_ff;
   logic [IDX_OUT_W-1:0]    best_idx_ff;
   logic [IDX_OUT_W-1:0]    res_idx_ff;
   logic                    res_full_ff;

   // Item capture and configuration.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_command;
         a_ff[0] <= req_ax;
         a_ff[1] <= req_ay;
         a_ff[2] <= req_az;
         b_ff[0] <= req_bx;
         b_ff[1] <= req_by;
         b_ff[2] <= req_bz;
         tol_ff <= req_tolerance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_X: org_ff[0] <= csr_wdata;
            CSR_ORIGIN_Y: org_ff[1] <= csr_wdata;
            CSR_ORIGIN_Z: org_ff[2] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Table loads and counts.
   assign pt_full = (pt_cnt_ff == PCW'(MAX_POINTS));
   assign ax_full = (ax_cnt_ff == ACW'(MAX_AXIS_SEGS));
   assign lv_full = (lv_cnt_ff == LCW'(MAX_LEVEL_SEGS));
   assign pt_we = cmd.exec && (cmd_ff == CMD_LOAD_POINT) && !pt_full;
   assign ax_we = cmd.exec && (cmd_ff == CMD_LOAD_AXIS) && !ax_full;
   assign lv_we = cmd.exec && (cmd_ff == CMD_LOAD_LEVEL) && !lv_full;

   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[pt_cnt_ff[PAW-1:0]] <= {a_ff[0], a_ff[1], a_ff[2]};
      end
      if (cmd.rd_en) begin
         pt_rd_ff <= pt_mem[idx_ff[PAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (ax_we) begin
         ax_mem[ax_cnt_ff[AAW-1:0]] <= {a_ff[0], a_ff[1], a_ff[2],
                                        b_ff[0], b_ff[1], b_ff[2]};
      end
      if (cmd.rd_en) begin
         ax_rd_ff <= ax_mem[idx_ff[AAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (lv_we) begin
         lv_mem[lv_cnt_ff[LAW-1:0]] <= {a_ff[0], a_ff[1], a_ff[2],
                                        b_ff[0], b_ff[1], b_ff[2]};
      end
      if (cmd.rd_en) begin
         lv_rd_ff <= lv_mem[idx_ff[LAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_cnt_ff <= '0;
         ax_cnt_ff <= '0;
         lv_cnt_ff <= '0;
      end else if (cmd.exec) begin
         if (cmd_ff == CMD_CLEAR) begin
            pt_cnt_ff <= '0;
            ax_cnt_ff <= '0;
            lv_cnt_ff <= '0;
         end
         if (pt_we) begin
            pt_cnt_ff <= pt_cnt_ff + PCW'(1);
         end
         if (ax_we) begin
            ax_cnt_ff <= ax_cnt_ff + ACW'(1);
         end
         if (lv_we) begin
            lv_cnt_ff <= lv_cnt_ff + LCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_idx_ff <= '0;
         res_full_ff <= 1'b0;
         case (cmd_ff)
            CMD_LOAD_POINT: begin
               res_full_ff <= pt_full;
               if (!pt_full) begin
                  res_idx_ff <= IDX_OUT_W'(pt_cnt_ff);
               end
            end
            CMD_LOAD_AXIS: begin
               res_full_ff <= ax_full;
               if (!ax_full) begin
                  res_idx_ff <= IDX_OUT_W'(ax_cnt_ff);
               end
            end
            CMD_LOAD_LEVEL: begin
               res_full_ff <= lv_full;
               if (!lv_full) begin
                  res_idx_ff <= IDX_OUT_W'(lv_cnt_ff);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Scan index.
   always_ff @(posedge clock) begin
      if (reset || cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + IW'(1);
      end
   end

   assign idx_nx = {1'b0, idx_ff} + (IW + 1)'(1);

   // Shared multiplier.
   always_comb begin
      q_sel = a_ff[2];
      c_sel = cand_ff[2];
      v_sel = v_ff[2];
      w_sel = w_ff[2];
      case (cmd.axis)
         2'd0: begin
            q_sel = a_ff[0];
            c_sel = cand_ff[0];
            v_sel = v_ff[0];
            w_sel = w_ff[0];
         end
         2'd1: begin
            q_sel = a_ff[1];
            c_sel = cand_ff[1];
            v_sel = v_ff[1];
            w_sel = w_ff[1];
         end
         default: begin
         end
      endcase
      diff = $signed({q_sel[COORD_W-1], q_sel}) - $signed({c_sel[COORD_W-1], c_sel});
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         MUL_TOL: begin
            mul_a = $signed(MUL_W'(tol_ff));
            mul_b = $signed(MUL_W'(tol_ff));
         end
         MUL_DIFF: begin
            mul_a = MUL_W'(diff);
            mul_b = MUL_W'(diff);
         end
         MUL_VV: begin
            mul_a = MUL_W'(v_sel);
            mul_b = MUL_W'(v_sel);
         end
         MUL_VW: begin
            mul_a = MUL_W'(v_sel);
            mul_b = MUL_W'(w_sel);
         end
         MUL_VT: begin
            mul_a = MUL_W'(v_sel);
            mul_b = $signed(MUL_W'(t_ff));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Accumulators, segment setup, divider and projection.
   assign seg_rd = (cmd.kind == KIND_LEVEL) ? lv_rd_ff : ax_rd_ff;
   assign rem_sh = {rem_ff[REM_W-2:0], 1'b0};

   always_ff @(posedge clock) begin
      if (cmd.tol_wr) begin
         tol_sq_ff <= prod_ff[TSQ_W-1:0];
      end
      if (cmd.dist_clr) begin
         dist_ff <= '0;
      end else if (cmd.acc_op == ACC_DIST) begin
         dist_ff <= dist_ff + prod_ff[SQ_W-1:0];
      end
      if (cmd.seg_ld) begin
         len_ff <= '0;
         dot_ff <= '0;
      end else if (cmd.acc_op == ACC_LEN) begin
         len_ff <= len_ff + prod_ff[SQ_W-1:0];
      end else if (cmd.acc_op == ACC_DOT) begin
         dot_ff <= dot_ff + prod_ff;
      end
      if (cmd.seg_ld) begin
         for (int i = 0; i < 3; i++) begin
            s_ff[i] <= seg_rd[SEG_W-1-COORD_W*i -: COORD_W];
            v_ff[i] <= $signed({seg_rd[PT_W-1-COORD_W*i], seg_rd[PT_W-1-COORD_W*i -: COORD_W]})
                     - $signed({seg_rd[SEG_W-1-COORD_W*i],
                                seg_rd[SEG_W-1-COORD_W*i -: COORD_W]});
            w_ff[i] <= $signed({a_ff[i][COORD_W-1], a_ff[i]})
                     - $signed({seg_rd[SEG_W-1-COORD_W*i],
                                seg_rd[SEG_W-1-COORD_W*i -: COORD_W]});
         end
      end
      if (cmd.t_zero) begin
         t_ff <= '0;
      end else if (cmd.t_one) begin
         t_ff <= T_ONE;
      end else if (cmd.div_init) begin
         t_ff <= '0;
         rem_ff <= dot_ff[REM_W-1:0];
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, len_ff}) begin
            rem_ff <= rem_sh - {1'b0, len_ff};
            t_ff <= {t_ff[T_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            t_ff <= {t_ff[T_W-2:0], 1'b0};
         end
      end
      if (cmd.cand_org) begin
         cand_ff <= org_ff;
      end else if (cmd.cand_pt) begin
         cand_ff[0] <= pt_rd_ff[PT_W-1 -: COORD_W];
         cand_ff[1] <= pt_rd_ff[PT_W-1-COORD_W -: COORD_W];
         cand_ff[2] <= pt_rd_ff[COORD_W-1:0];
      end else if (cmd.cand_proj) begin
         case (cmd.wr_axis)
            2'd0: cand_ff[0] <= s_ff[0] + prod_ff[COORD_W+15:16];
            2'd1: cand_ff[1] <= s_ff[1] + prod_ff[COORD_W+15:16];
            default: cand_ff[2] <= s_ff[2] + prod_ff[COORD_W+15:16];
         endcase
      end
   end

   // Best candidate.
   assign upd = (dist_ff <= SQ_W'(tol_sq_ff)) && (!best_have_ff || dist_ff < best_dsq_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.best_clr) begin
         best_have_ff <= 1'b0;
      end else if (cmd.cmp_upd && upd) begin
         best_have_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cmp_upd && upd) begin
         best_kind_ff <= cmd.kind;
         best_p_ff <= cand_ff;
         best_dsq_ff <= dist_ff;
         best_idx_ff <= IDX_OUT_W'(idx_ff);
      end
   end

   // Status.
   always_comb begin
      sts.cmd = cmd_ff;
      sts.pt_nz = (pt_cnt_ff != '0);
      sts.ax_nz = (ax_cnt_ff != '0);
      sts.lv_nz = (lv_cnt_ff != '0);
      sts.pt_last = (idx_nx >= (IW + 1)'(pt_cnt_ff));
      sts.ax_last = (idx_nx >= (IW + 1)'(ax_cnt_ff));
      sts.lv_last = (idx_nx >= (IW + 1)'(lv_cnt_ff));
      sts.degen = (len_ff < DEGEN_LEN_SQ);
      sts.dot_pos = (dot_ff > 0);
      sts.dot_ge_len = (dot_ff[REM_W-1:0] >= {1'b0, len_ff});
      sts.best_have = best_have_ff;
      sts.best_point = (best_kind_ff == KIND_POINT);
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (cmd_ff == CMD_QUERY) begin
            rsp_snapped <= best_have_ff;
            rsp_table_full <= 1'b0;
            if (best_have_ff) begin
               rsp_snap_kind <= best_kind_ff;
               rsp_snap_x <= best_p_ff[0];
               rsp_snap_y <= best_p_ff[1];
               rsp_snap_z <= best_p_ff[2];
               rsp_dist_sq <= (best_dsq_ff[SQ_W-1:DSQ_W] != '0) ? '1
                                                                 : best_dsq_ff[DSQ_W-1:0];
               rsp_entry_index <= best_idx_ff;
            end else begin
               rsp_snap_kind <= KIND_NONE;
               rsp_snap_x <= '0;
               rsp_snap_y <= '0;
               rsp_snap_z <= '0;
               rsp_dist_sq <= '1;
               rsp_entry_index <= '0;
            end
         end else begin
            rsp_snapped <= 1'b0;
            rsp_snap_kind <= KIND_NONE;
            rsp_snap_x <= '0;
            rsp_snap_y <= '0;
            rsp_snap_z <= '0;
            rsp_dist_sq <= '0;
            rsp_entry_index <= res_idx_ff;
            rsp_table_full <= res_full_ff;
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/nearest_grid_snap_search_core.sv =====
// Nearest grid snap search core: controller plus datapath around one shared multiplier.
// A clear or load beat goes through decode and finish. A query checks the origin, each
// point and, unless a point snapped, each axis and level segment; a projection inside
// a segment uses a one-bit-per-cycle divider. The core takes one beat at a time.
// Reset is synchronous and empties all three tables and zeroes the origin registers.
`default_nettype none

module nearest_grid_snap_search_core #(
   parameter int MAX_POINTS = ngss_pkg::MAX_POINTS_DEF,
   parameter int MAX_AXIS_SEGS = ngss_pkg::MAX_AXIS_SEGS_DEF,
   parameter int MAX_LEVEL_SEGS = ngss_pkg::MAX_LEVEL_SEGS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [2:0]                           req_command,
   input  wire  [ngss_pkg::COORD_W-1:0]         req_ax,
   input  wire  [ngss_pkg::COORD_W-1:0]         req_ay,
   input  wire  [ngss_pkg::COORD_W-1:0]         req_az,
   input  wire  [ngss_pkg::COORD_W-1:0]         req_bx,
   input  wire  [ngss_pkg::COORD_W-1:0]         req_by,
   input  wire  [ngss_pkg::COORD_W-1:0]         req_bz,
   input  wire  [ngss_pkg::TOL_W-1:0]           req_tolerance,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic                                 rsp_snapped,
   output logic [2:0]                           rsp_snap_kind,
   output logic [ngss_pkg::COORD_W-1:0]         rsp_snap_x,
   output logic [ngss_pkg::COORD_W-1:0]         rsp_snap_y,
   output logic [ngss_pkg::COORD_W-1:0]         rsp_snap_z,
   output logic [ngss_pkg::DSQ_W-1:0]           rsp_dist_sq,
   output logic [ngss_pkg::IDX_OUT_W-1:0]       rsp_entry_index,
   output logic                                 rsp_table_full,
   input  wire                                  csr_we,
   input  wire  [ngss_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [ngss_pkg::COORD_W-1:0]         csr_wdata
);
   import ngss_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   ngss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ngss_dpath #(
      .MAX_POINTS     (MAX_POINTS),
      .MAX_AXIS_SEGS  (MAX_AXIS_SEGS),
      .MAX_LEVEL_SEGS (MAX_LEVEL_SEGS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_command),
      .req_ax          (req_ax),
      .req_ay          (req_ay),
      .req_az          (req_az),
      .req_bx          (req_bx),
      .req_by          (req_by),
      .req_bz          (req_bz),
      .req_tolerance   (req_tolerance),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_snapped     (rsp_snapped),
      .rsp_snap_kind   (rsp_snap_kind),
      .rsp_snap_x      (rsp_snap_x),
      .rsp_snap_y      (rsp_snap_y),
      .rsp_snap_z      (rsp_snap_z),
      .rsp_dist_sq     (rsp_dist_sq),
      .rsp_entry_index (rsp_entry_index),
      .rsp_table_full  (rsp_table_full)
   );

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side open right after an accepted beat");

   a_snap_has_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_snapped |-> rsp_snap_kind != KIND_NONE && !rsp_table_full)
      else $error("snapped result without a kind");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> !rsp_snapped && rsp_entry_index == '0)
      else $error("dropped load reports an entry");
`endif

endmodule

`default_nettype wire

// ===== tb/nearest_grid_snap_search_core_tb.sv =====
// Self-checking testbench for nearest_grid_snap_search_core: directed table, then
// random runs of clears, loads and nearby queries, scored by a predictor unless fixed.
// Depends on ngss_pkg and the core; uses valid/stall handshakes with random idling.
`default_nettype none

module nearest_grid_snap_search_core_tb;
   import ngss_pkg::*;

   localparam int NPTS = MAX_POINTS_DEF;
   localparam int NAX = MAX_AXIS_SEGS_DEF;
   localparam int NLV = MAX_LEVEL_SEGS_DEF;
   localparam int LIMIT = 2000000;
   localparam logic [2:0] CMD_RSVD5 = 3'd5;
   localparam logic [2:0] CMD_RSVD6 = 3'd6;
   localparam logic [2:0] CMD_RSVD7 = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [127:0] DEGEN = 128'd4295;

   typedef logic [127:0] wide_t;
   typedef longint vec3[3];

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] ax, ay, az, bx, by, bz;
      logic [30:0] tol;
   } snap_req;

   typedef struct packed {
      logic        snapped;
      logic [2:0]  kind;
      logic [31:0] x, y, z;
      logic [63:0] dsq;
      logic [7:0]  idx;
      logic        full;
   } snap_rsp;

   typedef struct {
      snap_req it;
      bit      fixed;
      snap_rsp res;
   } table_row;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [2:0] req_command;
   logic [31:0] req_ax, req_ay, req_az, req_bx, req_by, req_bz;
   logic [30:0] req_tolerance;
   logic rsp_valid, rsp_stall, rsp_snapped, rsp_table_full;
   logic [2:0] rsp_snap_kind;
   logic [31:0] rsp_snap_x, rsp_snap_y, rsp_snap_z;
   logic [63:0] rsp_dist_sq;
   logic [7:0] rsp_entry_index;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0] csr_wdata;

   nearest_grid_snap_search_core dut (.*);

   // Predictor state
   longint org_x, org_y, org_z;
   vec3 pt_tab[NPTS];
   vec3 ax_s[NAX], ax_e[NAX], lv_s[NLV], lv_e[NLV];
   int pt_cnt, ax_cnt, lv_cnt;

   snap_rsp pending_q[$];
   longint near_x[$], near_y[$], near_z[$];
   int errors, checked, hits, drops, sent, cycles;
   int hold_req, hold_seen, hold_left, burst_left;
   bit quiet;

   initial begin
      clock = 0;
   end
   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic wide_t mag_sq(longint d);
      longint unsigned m;
      m = d < 0 ? -d : d;
      return wide_t'(m) * wide_t'(m);
   endfunction

   function automatic wide_t dist3(vec3 p, vec3 q);
      wide_t s;
      s = 0;
      for (int i = 0; i < 3; i++) s += mag_sq(p[i] - q[i]);
      return s;
   endfunction

   function automatic bit project_onto(vec3 s, vec3 e, vec3 p, output vec3 o);
      wide_t len, pos, neg, pr, r;
      longint unsigned mv, mw;
      longint v[3];
      longint w, t;
      len = 0; pos = 0; neg = 0; t = 0;
      for (int i = 0; i < 3; i++) begin
         v[i] = e[i] - s[i];
         w = p[i] - s[i];
         mv = v[i] < 0 ? -v[i] : v[i];
         mw = w < 0 ? -w : w;
         len += wide_t'(mv) * wide_t'(mv);
         pr = wide_t'(mv) * wide_t'(mw);
         if ((v[i] < 0) != (w < 0)) neg += pr;
         else pos += pr;
      end
      if (len < DEGEN) return 0;
      if (pos > neg) begin
         r = pos - neg;
         if (r >= len) t = 65536;
         else begin
            for (int k = 0; k < 16; k++) begin
               r = r << 1;
               t = t << 1;
               if (r >= len) begin
                  r -= len;
                  t |= 1;
               end
            end
         end
      end
      for (int i = 0; i < 3; i++) o[i] = s[i] + ((v[i] * t) >>> 16);
      return 1;
   endfunction

   function automatic snap_rsp snap_predict(snap_req it);
      snap_rsp r;
      vec3 a, b, c, o;
      wide_t tol, d, bd;
      bit have;
      logic [2:0] bk;
      vec3 bp;
      int bi;
      r = '0;
      a[0] = longint'($signed(it.ax)); a[1] = longint'($signed(it.ay));
      a[2] = longint'($signed(it.az));
      b[0] = longint'($signed(it.bx)); b[1] = longint'($signed(it.by));
      b[2] = longint'($signed(it.bz));
      case (it.cmd)
         CMD_CLEAR: begin
            pt_cnt = 0; ax_cnt = 0; lv_cnt = 0;
         end
         CMD_LOAD_POINT: begin
            if (pt_cnt < NPTS) begin
               pt_tab[pt_cnt] = a;
               r.idx = pt_cnt[7:0];
               pt_cnt++;
            end else r.full = 1;
         end
         CMD_LOAD_AXIS: begin
            if (ax_cnt < NAX) begin
               ax_s[ax_cnt] = a; ax_e[ax_cnt] = b;
               r.idx = ax_cnt[7:0];
               ax_cnt++;
            end else r.full = 1;
         end
         CMD_LOAD_LEVEL: begin
            if (lv_cnt < NLV) begin
               lv_s[lv_cnt] = a; lv_e[lv_cnt] = b;
               r.idx = lv_cnt[7:0];
               lv_cnt++;
            end else r.full = 1;
         end
         CMD_QUERY: begin
            tol = wide_t'(it.tol) * wide_t'(it.tol);
            have = 0; bk = KIND_NONE; bd = 0; bi = 0; bp = '{0, 0, 0};
            c = '{org_x, org_y, org_z};
            d = dist3(a, c);
            if (d <= tol) begin
               have = 1; bk = KIND_ORIGIN; bd = d; bp = c; bi = 0;
            end
            for (int k = 0; k < pt_cnt; k++) begin
               d = dist3(a, pt_tab[k]);
               if (d <= tol && (!have || d < bd)) begin
                  have = 1; bk = KIND_POINT; bd = d; bp = pt_tab[k]; bi = k;
               end
            end
            if (!(have && bk == KIND_POINT)) begin
               for (int k = 0; k < ax_cnt; k++) begin
                  if (project_onto(ax_s[k], ax_e[k], a, o)) begin
                     d = dist3(a, o);
                     if (d <= tol && (!have || d < bd)) begin
                        have = 1; bk = KIND_AXIS; bd = d; bp = o; bi = k;
                     end
                  end
               end
               for (int k = 0; k < lv_cnt; k++) begin
                  if (project_onto(lv_s[k], lv_e[k], a, o)) begin
                     d = dist3(a, o);
                     if (d <= tol && (!have || d < bd)) begin
                        have = 1; bk = KIND_LEVEL; bd = d; bp = o; bi = k;
                     end
                  end
               end
            end
            if (have) begin
               r.snapped = 1;
               r.kind = bk;
               r.x = bp[0][31:0]; r.y = bp[1][31:0]; r.z = bp[2][31:0];
               r.dsq = bd[127:64] != 0 ? '1 : bd[63:0];
               r.idx = bi[7:0];
            end else r.dsq = '1;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Response side: scoreboard and stall generation.
   always @(posedge clock) begin
      snap_rsp e;
      if (reset) begin
         rsp_stall <= 0;
         hold_left <= 0;
         burst_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_q.size() == 0) begin
               $error("response beat with nothing expected");
               errors++;
            end else begin
               e = pending_q.pop_front();
               checked++;
               if (e.snapped && e.kind != KIND_ORIGIN) hits++;
               if (rsp_snapped !== e.snapped) begin
                  $error("snapped exp %0h got %0h", e.snapped, rsp_snapped); errors++;
               end
               if (rsp_snap_kind !== e.kind) begin
                  $error("snap_kind exp %0h got %0h", e.kind, rsp_snap_kind); errors++;
               end
               if (rsp_snap_x !== e.x) begin
                  $error("snap_x exp %0h got %0h", e.x, rsp_snap_x); errors++;
               end
               if (rsp_snap_y !== e.y) begin
                  $error("snap_y exp %0h got %0h", e.y, rsp_snap_y); errors++;
               end
               if (rsp_snap_z !== e.z) begin
                  $error("snap_z exp %0h got %0h", e.z, rsp_snap_z); errors++;
               end
               if (rsp_dist_sq !== e.dsq) begin
                  $error("dist_sq exp %0h got %0h", e.dsq, rsp_dist_sq); errors++;
               end
               if (rsp_entry_index !== e.idx) begin
                  $error("entry_index exp %0h got %0h", e.idx, rsp_entry_index); errors++;
               end
               if (rsp_table_full !== e.full) begin
                  $error("table_full exp %0h got %0h", e.full, rsp_table_full); errors++;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1;
            hold_left <= hold_left - 1;
         end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 400;
            rsp_stall <= 1;
         end else if (quiet) begin
            rsp_stall <= 0;
         end else if (burst_left > 0) begin
            rsp_stall <= 1;
            burst_left <= burst_left - 1;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
            burst_left <= $urandom_range(0, 2);
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   task automatic send(snap_req it, bit fixed = 0, snap_rsp res = '0);
      snap_rsp p;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_command <= it.cmd;
      req_ax <= it.ax; req_ay <= it.ay; req_az <= it.az;
      req_bx <= it.bx; req_by <= it.by; req_bz <= it.bz;
      req_tolerance <= it.tol;
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = snap_predict(it);
      if (p.full) drops++;
      pending_q.push_back(fixed ? res : p);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         CSR_ORIGIN_X: org_x = longint'($signed(val));
         CSR_ORIGIN_Y: org_y = longint'($signed(val));
         CSR_ORIGIN_Z: org_z = longint'($signed(val));
         default: ;
      endcase
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   function automatic logic [30:0] rand_tol();
      case ($urandom_range(0, 7))
         0: return 31'd0;
         1: return $urandom_range(0, 31'h7fff_ffff);
         2: return 31'h7fff_ffff;
         default: return $urandom_range(0, 32'h4000);
      endcase
   endfunction

   function automatic snap_req mk(logic [2:0] cmd, logic [31:0] ax, ay, az, bx, by, bz,
                                  logic [30:0] tol);
      snap_req it;
      it.cmd = cmd; it.ax = ax; it.ay = ay; it.az = az;
      it.bx = bx; it.by = by; it.bz = bz; it.tol = tol;
      return it;
   endfunction

   function automatic snap_rsp load_ok(int idx);
      snap_rsp r;
      r = '0;
      r.idx = idx[7:0];
      return r;
   endfunction

   task automatic remember(longint x, longint y, longint z);
      near_x.push_back(x); near_y.push_back(y); near_z.push_back(z);
   endtask

   task automatic send_load(logic [2:0] cmd);
      snap_req it;
      longint f;
      it = mk(cmd, rand_coord(), rand_coord(), rand_coord(), 0, 0, 0, 0);
      if (cmd == CMD_LOAD_POINT) begin
         remember($signed(it.ax), $signed(it.ay), $signed(it.az));
      end else begin
         it.bx = it.ax; it.by = it.ay; it.bz = it.az;
         case ($urandom_range(0, 9))
            0: it.bx = it.ax + $urandom_range(0, 2);
            1: begin
               it.bx = rand_coord(); it.by = rand_coord(); it.bz = rand_coord();
            end
            default: begin
               if (cmd == CMD_LOAD_AXIS) begin
                  it.bx = it.ax + $urandom_range(0, 32'h40000) - 32'h20000;
                  it.by = it.ay + $urandom_range(0, 32'h40000) - 32'h20000;
               end else it.bz = it.az + $urandom_range(0, 32'h40000) - 32'h20000;
            end
         endcase
         for (int k = 0; k < 2; k++) begin
            f = $urandom_range(0, 8);
            remember($signed(it.ax) + ((longint'($signed(it.bx)) - $signed(it.ax)) * f) / 8,
                     $signed(it.ay) + ((longint'($signed(it.by)) - $signed(it.ay)) * f) / 8,
                     $signed(it.az) + ((longint'($signed(it.bz)) - $signed(it.az)) * f) / 8);
         end
      end
      send(it);
   endtask

   task automatic send_query();
      snap_req it;
      int k;
      it = mk(CMD_QUERY, rand_coord(), rand_coord(), rand_coord(),
              $urandom, $urandom, $urandom, rand_tol());
      if (near_x.size() != 0 && $urandom_range(0, 4) != 0) begin
         k = $urandom_range(0, near_x.size() - 1);
         it.ax = near_x[k] + $urandom_range(0, 32'h2000) - 32'h1000;
         it.ay = near_y[k] + $urandom_range(0, 32'h2000) - 32'h1000;
         it.az = near_z[k] + $urandom_range(0, 32'h2000) - 32'h1000;
      end
      send(it);
   endtask

   task automatic clear_all();
      send(mk(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom));
      near_x.delete(); near_y.delete(); near_z.delete();
   endtask

   task automatic session();
      int n;
      if ($urandom_range(0, 3) != 0) clear_all();
      n = $urandom_range(1, 9);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 2))
            0: send_load(CMD_LOAD_POINT);
            1: send_load(CMD_LOAD_AXIS);
            default: send_load(CMD_LOAD_LEVEL);
         endcase
         if ($urandom_range(0, 3) == 0) send_query();
      end
      n = $urandom_range(3, 8);
      for (int i = 0; i < n; i++) send_query();
      if ($urandom_range(0, 4) == 0)
         send(mk($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom));
   endtask

   task automatic fill_table(logic [2:0] cmd, int n);
      for (int i = 0; i < n; i++) send_load(cmd);
   endtask

   table_row dir_rows[$];
   snap_rsp res_zero, res_none, res_org;

   initial begin
      int s;
      reset = 1;
      req_valid = 0; req_command = CMD_CLEAR;
      req_ax = 0; req_ay = 0; req_az = 0; req_bx = 0; req_by = 0; req_bz = 0;
      req_tolerance = 0;
      csr_we = 0; csr_index = CSR_ORIGIN_X; csr_wdata = 0;
      errors = 0; checked = 0; hits = 0; drops = 0; sent = 0; cycles = 0;
      hold_req = 0; hold_seen = 0; quiet = 0;
      org_x = 0; org_y = 0; org_z = 0;
      pt_cnt = 0; ax_cnt = 0; lv_cnt = 0;
      res_zero = '0;
      res_none = '0; res_none.dsq = '1;
      res_org = '0; res_org.snapped = 1; res_org.kind = KIND_ORIGIN;

      dir_rows = '{
         '{mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0), 1, res_org},
         '{mk(CMD_QUERY, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0),
           1, res_none},
         '{mk(CMD_RSVD5, '1, '1, '1, '1, '1, '1, '1), 1, res_zero},
         '{mk(CMD_RSVD7, 1, 2, 3, 4, 5, 6, 7), 1, res_zero},
         '{mk(CMD_LOAD_POINT, 32'h10000, 0, 0, 0, 0, 0, 0), 1, load_ok(0)},
         '{mk(CMD_LOAD_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0),
           1, load_ok(1)},
         '{mk(CMD_LOAD_AXIS, 0, 0, 0, 32'h100000, 0, 0, 0), 1, load_ok(0)},
         '{mk(CMD_LOAD_LEVEL, 32'h20000, 0, 0, 32'h20000, 0, 32'h100000, 0), 1, load_ok(0)},
         '{mk(CMD_LOAD_LEVEL, 5, 5, 5, 5, 5, 5, 0), 1, load_ok(1)},
         '{mk(CMD_QUERY, 32'h10003, 0, 0, 0, 0, 0, 32'h100), 0, res_zero},
         '{mk(CMD_QUERY, 32'h8000, 32'h4000, 0, 0, 0, 0, 32'h10000), 0, res_zero},
         '{mk(CMD_QUERY, 32'h50000, 32'h100, 0, 0, 0, 0, 32'h10000), 0, res_zero},
         '{mk(CMD_QUERY, 32'h20005, 0, 32'h80000, 0, 0, 0, 32'h10000), 0, res_zero},
         '{mk(CMD_QUERY, 32'hffff_f000, 32'h10, 0, 0, 0, 0, 32'h2000), 0, res_zero},
         '{mk(CMD_QUERY, 32'h200000, 32'h30, 32'h7, 0, 0, 0, 32'h7fff_ffff), 0, res_zero},
         '{mk(CMD_QUERY, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '1, '1, '1,
              32'h7fff_ffff), 0, res_zero},
         '{mk(CMD_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0,
              32'h7fff_ffff), 0, res_zero},
         '{mk(CMD_RSVD6, 0, 0, 0, 0, 0, 0, 0), 1, res_zero},
         '{mk(CMD_CLEAR, 9, 9, 9, 9, 9, 9, 9), 1, res_zero},
         '{mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff), 1, res_org}
      };

      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].res);

      // Fill every table past capacity, with the response side holding off at the start.
      hold_req++;
      fill_table(CMD_LOAD_POINT, NPTS + 2);
      fill_table(CMD_LOAD_AXIS, NAX + 1);
      fill_table(CMD_LOAD_LEVEL, NLV + 1);
      send_query();
      send_query();
      clear_all();

      drain();
      write_csr(CSR_ORIGIN_X, 32'h8000_0000);
      write_csr(CSR_ORIGIN_Y, 32'h7fff_ffff);
      write_csr(CSR_ORIGIN_Z, 32'h0);
      write_csr(CSR_UNUSED, 32'h1234_5678);
      send(mk(CMD_QUERY, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0, 0));
      send(mk(CMD_QUERY, 32'h8000_0010, 32'h7fff_fff0, 0, 0, 0, 0, 32'h100));

      s = 0;
      while (sent < 1100) begin
         if (s % 20 == 19) begin
            drain();
            write_csr(CSR_ORIGIN_X, rand_coord());
            write_csr(CSR_ORIGIN_Y, rand_coord());
            write_csr(CSR_ORIGIN_Z, rand_coord());
            if (near_x.size() != 0) begin
               remember(org_x, org_y, org_z);
            end
         end
         if (s == 30) hold_req++;
         if (sent > 1000) quiet = 1;
         session();
         s++;
      end

      drain();
      repeat (50) @(posedge clock);
      $display("Run covered %0d request beats and %0d checked responses,", sent, checked);
      $display("with %0d snaps to table targets and %0d loads dropped on a full table.",
               hits, drops);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
src/ngss_pkg.sv
src/ngss_ctrl.sv
src/ngss_dpath.sv
src/nearest_grid_snap_search_core.sv
tb/nearest_grid_snap_search_core_tb.sv
